### sv/ifp_pkg.sv
// Shared constants and controller/datapath link types for the iBus frame parser.
package ifp_pkg;

  localparam int BYTE_W          = 8;
  localparam int IDX_FIELD_W     = 4;
  localparam int VAL_W           = 16;
  localparam int CNT_W           = 5;
  localparam int FRAME_CHANNELS  = 14;
  localparam int PAYLOAD_BYTES   = 2 * FRAME_CHANNELS;
  localparam int NUM_CHANNELS_DEF = 14;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h20;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h40;
  localparam logic [VAL_W-1:0]  SUM_INIT   = 16'hFFFF;

  typedef struct packed {
    logic start_sum;
    logic sub_sum;
    logic clr_count;
    logic store_byte;
    logic load_ck_lo;
    logic clr_emit;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic hdr_first;
    logic hdr_second;
    logic payload_end;
    logic ck_match;
    logic emit_end;
    logic out_free;
  } sts_t;

endpackage

### sv/ifp_if.sv
// Handshake interfaces for the received byte channel and the channel result channel.
interface ifp_in_if import ifp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifp_out_if import ifp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [IDX_FIELD_W-1:0] channel_index;
  logic [VAL_W-1:0]       channel_value;
  logic                   last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

### sv/ifp_ctrl.sv
// Frame parser state machine that sequences the header, payload, checksum and emit phases.
module ifp_ctrl import ifp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_HUNT    = 3'd0;
  localparam logic [2:0] ST_HDR     = 3'd1;
  localparam logic [2:0] ST_PAYLOAD = 3'd2;
  localparam logic [2:0] ST_CK_LO   = 3'd3;
  localparam logic [2:0] ST_CK_HI   = 3'd4;
  localparam logic [2:0] ST_EMIT    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       acc;

  assign in_ready = (state_r != ST_EMIT);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_HUNT: begin
        if (acc && sts.hdr_first) begin
          cmd.start_sum = 1'b1;
          cmd.clr_count = 1'b1;
          state_nxt     = ST_HDR;
        end
      end
      ST_HDR: begin
        if (acc) begin
          cmd.clr_count = 1'b1;
          if (sts.hdr_second) begin
            cmd.sub_sum = 1'b1;
            state_nxt   = ST_PAYLOAD;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_PAYLOAD: begin
        if (acc) begin
          cmd.store_byte = 1'b1;
          cmd.sub_sum    = 1'b1;
          if (sts.payload_end) begin
            state_nxt = ST_CK_LO;
          end
        end
      end
      ST_CK_LO: begin
        if (acc) begin
          cmd.load_ck_lo = 1'b1;
          state_nxt      = ST_CK_HI;
        end
      end
      ST_CK_HI: begin
        if (acc) begin
          cmd.clr_count = 1'b1;
          if (sts.ck_match) begin
            cmd.clr_emit = 1'b1;
            state_nxt    = ST_EMIT;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_end) begin
            state_nxt = ST_HUNT;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !(sts.emit_end && sts.out_free)) |=> state_r == ST_EMIT)
    else $error("emit sequence left before the final channel");

  a_match_enters_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CK_HI && acc && sts.ck_match) |=> state_r == ST_EMIT)
    else $error("matching checksum did not start the emit sequence");

endmodule

### sv/ifp_dp.sv
// Datapath with byte counter, running checksum, channel store and registered result stage.
module ifp_dp import ifp_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [BYTE_W-1:0]      rx_byte,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [IDX_FIELD_W-1:0] out_channel_index,
  output logic [VAL_W-1:0]       out_channel_value,
  output logic                   out_last_channel
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  logic [CNT_W-1:0]       byte_count_r;
  logic [VAL_W-1:0]       running_sum_r;
  logic [BYTE_W-1:0]      ck_lo_r;
  logic [IDX_W-1:0]       emit_idx_r;
  logic                   out_valid_r;
  logic [IDX_FIELD_W-1:0] out_idx_r;
  logic [VAL_W-1:0]       out_val_r;
  logic                   out_last_r;
  logic [VAL_W-1:0]       store_r [NUM_CHANNELS];
  logic [3:0]             wr_ch;
  logic [IDX_W-1:0]       wr_idx;

  assign wr_ch  = byte_count_r[CNT_W-1:1];
  assign wr_idx = wr_ch[IDX_W-1:0];

  assign sts.hdr_first   = (rx_byte == HDR_FIRST);
  assign sts.hdr_second  = (rx_byte == HDR_SECOND);
  assign sts.payload_end = (byte_count_r == CNT_W'(PAYLOAD_BYTES - 1));
  assign sts.ck_match    = ({rx_byte, ck_lo_r} == running_sum_r);
  assign sts.emit_end    = (emit_idx_r == LAST_IDX);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      running_sum_r <= SUM_INIT;
      ck_lo_r       <= '0;
      emit_idx_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.start_sum) begin
        running_sum_r <= SUM_INIT - VAL_W'(rx_byte);
      end else if (cmd.sub_sum) begin
        running_sum_r <= running_sum_r - VAL_W'(rx_byte);
      end
      if (cmd.clr_count) begin
        byte_count_r <= '0;
      end else if (cmd.store_byte) begin
        byte_count_r <= byte_count_r + CNT_W'(1);
      end
      if (cmd.load_ck_lo) begin
        ck_lo_r <= rx_byte;
      end
      if (cmd.clr_emit) begin
        emit_idx_r <= '0;
      end else if (cmd.emit_step) begin
        emit_idx_r <= emit_idx_r + IDX_W'(1);
      end
      if (cmd.emit_step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte && (wr_ch < 4'(NUM_CHANNELS))) begin
      if (!byte_count_r[0]) begin
        store_r[wr_idx] <= {8'h00, rx_byte};
      end else begin
        store_r[wr_idx][VAL_W-1:BYTE_W] <= rx_byte;
      end
    end
    if (cmd.emit_step) begin
      out_idx_r  <= IDX_FIELD_W'(emit_idx_r);
      out_val_r  <= store_r[emit_idx_r];
      out_last_r <= sts.emit_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_idx_r;
  assign out_channel_value = out_val_r;
  assign out_last_channel  = out_last_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_idx_r < IDX_FIELD_W'(NUM_CHANNELS)))
    else $error("channel index beyond the configured channel count");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_idx_r == IDX_FIELD_W'(NUM_CHANNELS - 1))))
    else $error("last mark disagrees with the channel index");

endmodule

### sv/ibus_frame_parser.sv
// Top level of the iBus frame parser: controller, datapath and channel hookup.
//
//   Channel  Direction  Payload                                       Moves per request
//   in_ch    sink       rx_byte[7:0]                                  one received byte
//   out_ch   source     channel_index[3:0], channel_value[15:0], last  one channel result
//
// in_ch is ready in every state but the emit run. A good frame's final byte
// starts an emit run of NUM_CHANNELS results, one per cycle while out_ch is
// free, from the channel store through the output register; in_ch is held off
// until the last one is loaded. Synchronous active-low reset returns to header
// hunting, presets the running checksum to SUM_INIT and clears the counters and
// out_valid; the channel store is not reset. A stalled out_ch pauses the run.
module ibus_frame_parser import ifp_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ifp_in_if.sink     in_ch,
  ifp_out_if.source  out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  ifp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ifp_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .rx_byte           (in_ch.rx_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_channel_index (out_ch.channel_index),
    .out_channel_value (out_ch.channel_value),
    .out_last_channel  (out_ch.last_channel)
  );

  assign in_ch.ready = in_ready;

endmodule

### sim/testbench.sv
// Self-checking testbench for the iBus frame parser: a table of directed frames, then random byte streams.
module testbench;
  import ifp_pkg::*;

  localparam int NCH          = NUM_CHANNELS_DEF;
  localparam int RANDOM_BYTES = 42;
  localparam int MAX_GAP      = 11;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [2:0] {PH_HUNT, PH_HDR, PH_PAYLOAD, PH_CK_LO, PH_CK_HI} phase_e;
  typedef enum logic [1:0] {ROW_BYTE, ROW_FILL, ROW_RAND} row_kind_e;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] index;
    logic [VAL_W-1:0]       value;
    logic                   last;
  } chan_res_t;

  typedef struct {
    row_kind_e         kind;
    logic [BYTE_W-1:0] data;
    logic [VAL_W-1:0]  ck_flip;
    bit                typed;
    int                want_count;
    logic [VAL_W-1:0]  want_value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ifp_in_if  in_ch ();
  ifp_out_if out_ch ();

  ibus_frame_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  phase_e            ph_state   = PH_HUNT;
  logic [CNT_W-1:0]  pay_count  = '0;
  logic [VAL_W-1:0]  ck_running = SUM_INIT;
  logic [BYTE_W-1:0] ck_low     = '0;
  logic [VAL_W-1:0]  chan_vals [FRAME_CHANNELS];
  chan_res_t         pending_channels [$];

  bit table_checked = 1'b0;
  bit calm          = 1'b0;
  int sent_bytes    = 0;
  int mismatches    = 0;
  int cycles        = 0;

  // Wrong second header bytes and a header byte in the wrong place come first, then filled frames
  // whose channels can be read off directly, with checksum errors in either byte, then random frames.
  stim_row_t directed_rows [18] = '{
    '{ROW_BYTE, 8'h00, 16'h0000, 1'b1, 0,   16'h0000},
    '{ROW_BYTE, 8'h40, 16'h0000, 1'b1, 0,   16'h0000},
    '{ROW_BYTE, 8'h20, 16'h0000, 1'b1, 0,   16'h0000},
    '{ROW_BYTE, 8'h41, 16'h0000, 1'b1, 0,   16'h0000},
    '{ROW_BYTE, 8'h20, 16'h0000, 1'b1, 0,   16'h0000},
    '{ROW_BYTE, 8'h20, 16'h0000, 1'b1, 0,   16'h0000},
    '{ROW_BYTE, 8'h40, 16'h0000, 1'b1, 0,   16'h0000},
    '{ROW_BYTE, 8'hFF, 16'h0000, 1'b1, 0,   16'h0000},
    '{ROW_FILL, 8'h00, 16'h0000, 1'b1, NCH, 16'h0000},
    '{ROW_FILL, 8'hFF, 16'h0000, 1'b1, NCH, 16'hFFFF},
    '{ROW_FILL, 8'h20, 16'h0000, 1'b1, NCH, 16'h2020},
    '{ROW_FILL, 8'h40, 16'h0000, 1'b1, NCH, 16'h4040},
    '{ROW_FILL, 8'hAA, 16'h0001, 1'b1, 0,   16'h0000},
    '{ROW_FILL, 8'h55, 16'h8000, 1'b1, 0,   16'h0000},
    '{ROW_FILL, 8'h55, 16'h0000, 1'b1, NCH, 16'h5555},
    '{ROW_RAND, 8'h00, 16'h0000, 1'b0, 0,   16'h0000},
    '{ROW_RAND, 8'h00, 16'hFFFF, 1'b0, 0,   16'h0000},
    '{ROW_RAND, 8'h00, 16'h0000, 1'b0, 0,   16'h0000}
  };

  function automatic void parse_byte(input logic [BYTE_W-1:0] b);
    int ch;
    logic [VAL_W-1:0] rx_ck;
    case (ph_state)
      PH_HDR: begin
        if (b == HDR_SECOND) begin
          ck_running = ck_running - b;
          ph_state   = PH_PAYLOAD;
        end else begin
          ph_state = PH_HUNT;
        end
        pay_count = '0;
      end
      PH_PAYLOAD: begin
        ch = int'(pay_count) >> 1;
        if (ch < NCH) begin
          if (!pay_count[0]) chan_vals[ch] = {8'h00, b};
          else chan_vals[ch][15:8] = b;
        end
        ck_running = ck_running - b;
        pay_count  = pay_count + 1'b1;
        if (pay_count >= PAYLOAD_BYTES) ph_state = PH_CK_LO;
      end
      PH_CK_LO: begin
        ck_low   = b;
        ph_state = PH_CK_HI;
      end
      PH_CK_HI: begin
        rx_ck = {b, ck_low};
        if (rx_ck == ck_running && !table_checked) begin
          for (int k = 0; k < NCH; k++)
            pending_channels.push_back(chan_res_t'{IDX_FIELD_W'(k), chan_vals[k], k == NCH - 1});
        end
        pay_count = '0;
        ph_state  = PH_HUNT;
      end
      default: begin
        if (b == HDR_FIRST) begin
          ck_running = SUM_INIT - b;
          pay_count  = '0;
          ph_state   = PH_HDR;
        end
      end
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] random_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    parse_byte(b);
    sent_bytes++;
  endtask

  // A body shorter than the full payload leaves the frame cut off without a checksum.
  task automatic send_frame(input bit random_body, input logic [BYTE_W-1:0] fill,
                            input logic [VAL_W-1:0] ck_flip, input int body_len);
    logic [BYTE_W-1:0] frame_bytes [$];
    logic [BYTE_W-1:0] pb;
    logic [VAL_W-1:0]  sum;
    frame_bytes = {HDR_FIRST, HDR_SECOND};
    sum = SUM_INIT - HDR_FIRST - HDR_SECOND;
    for (int i = 0; i < body_len; i++) begin
      pb = random_body ? random_byte() : fill;
      frame_bytes.push_back(pb);
      sum = sum - pb;
    end
    if (body_len == PAYLOAD_BYTES) begin
      sum = sum ^ ck_flip;
      frame_bytes.push_back(sum[7:0]);
      frame_bytes.push_back(sum[15:8]);
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_channels.size() != 0);
  endtask

  initial begin
    int start_bytes;
    int pick;
    bit paused;
    logic [BYTE_W-1:0] wrong;
    paused = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      table_checked = directed_rows[r].typed;
      if (table_checked) begin
        for (int k = 0; k < directed_rows[r].want_count; k++)
          pending_channels.push_back(chan_res_t'{IDX_FIELD_W'(k), directed_rows[r].want_value,
                                                 k == NCH - 1});
      end
      case (directed_rows[r].kind)
        ROW_BYTE: send_byte(directed_rows[r].data);
        ROW_FILL: send_frame(1'b0, directed_rows[r].data, directed_rows[r].ck_flip, PAYLOAD_BYTES);
        default:  send_frame(1'b1, 8'h00, directed_rows[r].ck_flip, PAYLOAD_BYTES);
      endcase
    end
    table_checked = 1'b0;
    drain_results();

    start_bytes = sent_bytes;
    while (sent_bytes - start_bytes < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        send_frame(1'b1, 8'h00, 16'h0000, PAYLOAD_BYTES);
      end else if (pick < 15) begin
        send_frame(1'b1, 8'h00, VAL_W'($urandom_range(1, 16'hFFFF)), PAYLOAD_BYTES);
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0:       send_byte(HDR_FIRST);
            1:       send_byte(HDR_SECOND);
            default: send_byte(random_byte());
          endcase
        end
      end else if (pick < 18) begin
        do wrong = BYTE_W'($urandom_range(0, 255)); while (wrong == HDR_SECOND);
        send_byte(HDR_FIRST);
        send_byte(wrong);
      end else begin
        send_frame(1'b1, 8'h00, 16'h0000, $urandom_range(0, PAYLOAD_BYTES - 1));
      end
      if (!paused && sent_bytes - start_bytes >= RANDOM_BYTES / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    calm = 1'b0;
    drain_results();
    repeat (NCH + 16) @(posedge clk);
    if (mismatches == 0 && pending_channels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int stall;
    chan_res_t got;
    chan_res_t want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      got = '{out_ch.channel_index, out_ch.channel_value, out_ch.last_channel};
      if (pending_channels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected channel result: index %0d value %h last %b",
                   got.index, got.value, got.last);
      end else begin
        want = pending_channels.pop_front();
        if (got.index !== want.index || got.value !== want.value || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("channel result mismatch: index %0d/%0d value %h/%h last %b/%b (exp/act)",
                     want.index, got.index, want.value, got.value, want.last, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

### files.f
sv/ifp_pkg.sv
sv/ifp_if.sv
sv/ifp_ctrl.sv
sv/ifp_dp.sv
sv/ibus_frame_parser.sv
sim/testbench.sv
